[rtl/ascal_pkg.sv]
// ascal_pkg: shared constants, command codes and beat types for the adc scan sequencer
// no dependencies; imported by the core, the checker and the testbench
`timescale 1ns / 1ps

package ascal_pkg;

    // block dimensions
    localparam int SCAN_LENGTH   = 6;
    localparam int SLOT_COUNT    = 8;
    localparam int SAMPLE_BITS   = 10;
    localparam int CAL_CHANNELS  = 8;
    localparam int ORDER_ENTRIES = 6;
    localparam int SUM_BITS      = SAMPLE_BITS + 8;
    localparam int SLOT_W        = $clog2(SLOT_COUNT);
    localparam int CH_W          = $clog2(CAL_CHANNELS);

    // command codes
    localparam logic [2:0] CMD_SCAN        = 3'd0;
    localparam logic [2:0] CMD_CAL_START   = 3'd1;
    localparam logic [2:0] CMD_CAL_SAMPLE  = 3'd2;
    localparam logic [2:0] CMD_READ_SNAP   = 3'd3;
    localparam logic [2:0] CMD_READ_OFFSET = 3'd4;
    localparam logic [2:0] CMD_READ_ROUNDS = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_ORDERED_SCAN = 2'd0;
    localparam logic [1:0] REG_SCAN_ORDER   = 2'd1;
    localparam logic [1:0] REG_CALIB_ROUNDS = 2'd2;

    localparam int CFG_DATA_W = 18;

    // configuration reset values
    localparam logic [17:0] SCAN_ORDER_RESET   = 18'd189896;
    localparam logic [7:0]  CALIB_ROUNDS_RESET = 8'd1;

    typedef struct packed {
        logic [2:0]             cmd;
        logic [SAMPLE_BITS-1:0] sample;
        logic [2:0]             slot_index;
        logic [7:0]             round_mask;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]             mux_channel;
        logic [SAMPLE_BITS-1:0] read_data;
        logic [7:0]             round_count;
        logic                   scan_wrapped;
        logic                   calib_done;
    } out_beat_t;

endpackage

[rtl/ascal_ram.sv]
// ascal_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ascal_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/adc_scan_sequencer_with_calibration_core.sv]
// adc_scan_sequencer_with_calibration_core: scan sequencer top level
// depends on ascal_pkg and ascal_ram
`timescale 1ns / 1ps

// Scan and calibration controller for a multiplexed 10-bit converter. One command beat
// in gives one result beat out. Storage sits in two 16-entry rams with a registered read:
// the slot ram holds the working slots in its lower half and the snapshot in its upper
// half, the calibration ram holds the sums in its lower half and the offsets in its upper
// half. Valid bits make never-written entries read as zero, so no clearing pass runs
// after reset. An ordinary beat passes through the execute and finish states to the output
// register, and the input is ready again only when the block is back in idle, so a new beat
// is not taken before the last one is through. A scan sample that wraps the scan also runs
// the working-to-snapshot copy, one ram entry per cycle. The calibration sample that ends
// a calibration also runs a shared restoring divider that forms one quotient bit per cycle,
// 18 bits for each of 8 channels, with a read, a load and a write state around each channel.
// The output register frees the input side while a result waits to be taken.
module adc_scan_sequencer_with_calibration_core
    import ascal_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EXEC  = 4'd1;
    localparam logic [3:0] ST_COPY  = 4'd2;
    localparam logic [3:0] ST_DRD   = 4'd3;
    localparam logic [3:0] ST_DLOAD = 4'd4;
    localparam logic [3:0] ST_DRUN  = 4'd5;
    localparam logic [3:0] ST_DWR   = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;

    localparam logic [2:0]        POS_LAST  = 3'(SCAN_LENGTH - 1);
    localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CAL_CHANNELS - 1);
    localparam logic [SLOT_W:0]   COPY_LAST = (SLOT_W + 1)'(SLOT_COUNT);
    localparam logic [4:0]        STEP_LAST = 5'(SUM_BITS - 1);

    // control state
    logic [3:0]        state_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;
    in_beat_t          in_reg;

    // configuration
    logic              ordered_scan_reg;
    logic [17:0]       scan_order_reg;
    logic [7:0]        calib_rounds_reg;

    // scalar state
    logic [2:0]        scan_pos_reg;
    logic [7:0]        rounds_seen_reg;
    logic [CH_W-1:0]   calib_ch_reg;
    logic [7:0]        calib_round_reg;
    logic              calib_active_reg;

    // per-entry valid bits
    logic [SLOT_COUNT-1:0]   work_vld_reg;
    logic [SLOT_COUNT-1:0]   snap_vld_reg;
    logic [CAL_CHANNELS-1:0] off_vld_reg;
    logic [CAL_CHANNELS-1:0] sum_vld_reg;

    // copy sweep and divider
    logic [SLOT_W:0]         cpy_cnt_reg;
    logic [CH_W-1:0]         div_ch_reg;
    logic [7:0]              div_den_reg;
    logic [7:0]              div_rem_reg;
    logic [SUM_BITS-1:0]     div_quo_reg;
    logic [4:0]              div_step_reg;

    // pending result fields
    logic [SAMPLE_BITS-1:0]  res_data_reg;
    logic                    res_wrapped_reg;
    logic                    res_done_reg;

    // ram ports
    logic                    work_we;
    logic                    snap_we;
    logic [SAMPLE_BITS-1:0]  snap_wdata;
    logic                    slot_we;
    logic [SLOT_W:0]         slot_waddr;
    logic [SAMPLE_BITS-1:0]  slot_wdata;
    logic [SLOT_W:0]         slot_raddr;
    logic [SAMPLE_BITS-1:0]  slot_rdata;
    logic                    sum_we;
    logic                    off_we;
    logic                    cal_we;
    logic [CH_W:0]           cal_waddr;
    logic [SUM_BITS-1:0]     cal_wdata;
    logic [CH_W:0]           cal_raddr;
    logic [SUM_BITS-1:0]     cal_rdata;

    // derived values
    logic [SUM_BITS-1:0]     sum_old;
    logic [SUM_BITS-1:0]     sum_new;
    logic [7:0]              round_inc;
    logic [7:0]              rounds_eff;
    logic [2:0]              scan_pos_next;
    logic                    scan_wrap;
    logic [SLOT_W-1:0]       cpy_idx;
    logic [8:0]              div_trial;
    logic                    div_ge;
    logic [2:0]              mux_next;
    logic                    scan_end;
    logic                    cal_end;
    logic [SAMPLE_BITS-1:0]  exec_data;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // read-modify-write and sweep arithmetic
    always_comb begin
        sum_old       = sum_vld_reg[calib_ch_reg] ? cal_rdata : '0;
        sum_new       = sum_old + SUM_BITS'(in_reg.sample);
        round_inc     = calib_round_reg + 8'd1;
        rounds_eff    = (calib_rounds_reg == 8'd0) ? 8'd1 : calib_rounds_reg;
        scan_wrap     = (scan_pos_reg == POS_LAST);
        scan_pos_next = scan_wrap ? 3'd0 : scan_pos_reg + 3'd1;
        cpy_idx       = SLOT_W'(cpy_cnt_reg - (SLOT_W + 1)'(1));
        div_trial     = {div_rem_reg, div_quo_reg[SUM_BITS-1]};
        div_ge        = (div_trial >= {1'b0, div_den_reg});
    end

    // next mux channel from the final state of this beat
    always_comb begin
        mux_next = 3'd0;
        if (res_done_reg) begin
            mux_next = 3'd0;
        end else if (calib_active_reg) begin
            mux_next = 3'(calib_ch_reg);
        end else if (!ordered_scan_reg) begin
            mux_next = scan_pos_reg;
        end else begin
            for (int k = 0; k < ORDER_ENTRIES; k++) begin
                if (scan_pos_reg == 3'(k)) begin
                    mux_next = scan_order_reg[3*k +: 3];
                end
            end
        end
    end

    // ram control: lower halves hold working slots and sums, upper halves snapshot and offsets
    always_comb begin
        work_we    = (state_reg == ST_EXEC) && (in_reg.cmd == CMD_SCAN) && !calib_active_reg;
        snap_we    = (state_reg == ST_COPY) && (cpy_cnt_reg != '0);
        snap_wdata = work_vld_reg[cpy_idx] ? slot_rdata : '0;
        slot_we    = work_we || snap_we;
        slot_waddr = snap_we ? {1'b1, cpy_idx} : {1'b0, SLOT_W'(scan_pos_reg)};
        slot_wdata = snap_we ? snap_wdata : in_reg.sample;
        slot_raddr = (state_reg == ST_COPY) ? {1'b0, cpy_cnt_reg[SLOT_W-1:0]}
                                            : {1'b1, SLOT_W'(s_data.slot_index)};
        sum_we     = (state_reg == ST_EXEC) && (in_reg.cmd == CMD_CAL_SAMPLE)
                     && calib_active_reg;
        off_we     = (state_reg == ST_DWR);
        cal_we     = sum_we || off_we;
        cal_waddr  = off_we ? {1'b1, div_ch_reg} : {1'b0, calib_ch_reg};
        cal_wdata  = off_we ? SUM_BITS'(div_quo_reg[SAMPLE_BITS-1:0]) : sum_new;
        if (state_reg == ST_DRD) begin
            cal_raddr = {1'b0, div_ch_reg};
        end else if (s_data.cmd == CMD_READ_OFFSET) begin
            cal_raddr = {1'b1, CH_W'(s_data.slot_index)};
        end else begin
            cal_raddr = {1'b0, calib_ch_reg};
        end
    end

    // result fields of the beat being executed
    always_comb begin
        scan_end = work_we && scan_wrap;
        cal_end  = sum_we && (calib_ch_reg == CH_LAST) && (round_inc >= rounds_eff);
        case (in_reg.cmd)
            CMD_READ_SNAP: begin
                exec_data = snap_vld_reg[SLOT_W'(in_reg.slot_index)] ? slot_rdata : '0;
            end
            CMD_READ_OFFSET: begin
                exec_data = off_vld_reg[CH_W'(in_reg.slot_index)] ?
                            cal_rdata[SAMPLE_BITS-1:0] : '0;
            end
            default: begin
                exec_data = '0;
            end
        endcase
    end

    ascal_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2 * SLOT_COUNT)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ascal_ram #(.WIDTH(SUM_BITS), .DEPTH(2 * CAL_CHANNELS)) u_cal_ram (
        .aclk  (aclk),
        .we    (cal_we),
        .waddr (cal_waddr),
        .wdata (cal_wdata),
        .raddr (cal_raddr),
        .rdata (cal_rdata)
    );

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_DLOAD) begin
            div_rem_reg <= '0;
            div_quo_reg <= sum_vld_reg[div_ch_reg] ? cal_rdata : '0;
        end else if (state_reg == ST_DRUN) begin
            div_rem_reg <= div_ge ? 8'(div_trial - {1'b0, div_den_reg}) : div_trial[7:0];
            div_quo_reg <= {div_quo_reg[SUM_BITS-2:0], div_ge};
        end
        if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
            m_data_reg.mux_channel  <= mux_next;
            m_data_reg.read_data    <= res_data_reg;
            m_data_reg.round_count  <= rounds_seen_reg;
            m_data_reg.scan_wrapped <= res_wrapped_reg;
            m_data_reg.calib_done   <= res_done_reg;
        end
    end

    // control state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            ordered_scan_reg <= 1'b0;
            scan_order_reg   <= SCAN_ORDER_RESET;
            calib_rounds_reg <= CALIB_ROUNDS_RESET;
            scan_pos_reg     <= '0;
            rounds_seen_reg  <= '0;
            calib_ch_reg     <= '0;
            calib_round_reg  <= '0;
            calib_active_reg <= 1'b0;
            work_vld_reg     <= '0;
            snap_vld_reg     <= '0;
            off_vld_reg      <= '0;
            sum_vld_reg      <= '0;
            cpy_cnt_reg      <= '0;
            div_ch_reg       <= '0;
            div_den_reg      <= 8'd1;
            div_step_reg     <= '0;
            res_data_reg     <= '0;
            res_wrapped_reg  <= 1'b0;
            res_done_reg     <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_ORDERED_SCAN: ordered_scan_reg <= cfg_data[0];
                    REG_SCAN_ORDER:   scan_order_reg   <= cfg_data[17:0];
                    REG_CALIB_ROUNDS: calib_rounds_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            // output register: filled from the finish state, emptied when taken
            if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end

                // ram read data is here: apply the command
                ST_EXEC: begin
                    res_data_reg    <= exec_data;
                    res_wrapped_reg <= scan_end;
                    res_done_reg    <= cal_end;
                    if (scan_end) begin
                        state_reg <= ST_COPY;
                    end else if (cal_end) begin
                        state_reg <= ST_DRD;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                    case (in_reg.cmd)
                        CMD_SCAN: begin
                            if (!calib_active_reg) begin
                                work_vld_reg[SLOT_W'(scan_pos_reg)] <= 1'b1;
                                scan_pos_reg <= scan_pos_next;
                                if (scan_wrap) begin
                                    rounds_seen_reg <= rounds_seen_reg + 8'd1;
                                    cpy_cnt_reg     <= '0;
                                end
                            end
                        end
                        CMD_CAL_START: begin
                            calib_active_reg <= 1'b1;
                            calib_ch_reg     <= '0;
                            calib_round_reg  <= '0;
                            sum_vld_reg      <= '0;
                        end
                        CMD_CAL_SAMPLE: begin
                            if (calib_active_reg) begin
                                sum_vld_reg[calib_ch_reg] <= 1'b1;
                                calib_ch_reg <= calib_ch_reg + CH_W'(1);
                                if (cal_end) begin
                                    calib_active_reg <= 1'b0;
                                    calib_round_reg  <= '0;
                                    div_ch_reg       <= '0;
                                    div_den_reg      <= rounds_eff;
                                end else if (calib_ch_reg == CH_LAST) begin
                                    calib_round_reg <= round_inc;
                                end
                            end
                        end
                        CMD_READ_ROUNDS: begin
                            rounds_seen_reg <= rounds_seen_reg & in_reg.round_mask;
                        end
                        default: ;
                    endcase
                end

                // working slots to snapshot, one entry per cycle
                ST_COPY: begin
                    if (cpy_cnt_reg != '0) begin
                        snap_vld_reg[cpy_idx] <= 1'b1;
                    end
                    if (cpy_cnt_reg == COPY_LAST) begin
                        state_reg <= ST_FIN;
                    end else begin
                        cpy_cnt_reg <= cpy_cnt_reg + (SLOT_W + 1)'(1);
                    end
                end

                ST_DRD: begin
                    state_reg <= ST_DLOAD;
                end

                ST_DLOAD: begin
                    div_step_reg <= '0;
                    state_reg    <= ST_DRUN;
                end

                // one quotient bit per cycle
                ST_DRUN: begin
                    div_step_reg <= div_step_reg + 5'd1;
                    if (div_step_reg == STEP_LAST) begin
                        state_reg <= ST_DWR;
                    end
                end

                ST_DWR: begin
                    off_vld_reg[div_ch_reg] <= 1'b1;
                    div_ch_reg <= div_ch_reg + CH_W'(1);
                    state_reg  <= (div_ch_reg == CH_LAST) ? ST_FIN : ST_DRD;
                end

                // hand the result to the output register once it is free
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/ascal_checker.sv]
// ascal_checker: port-level assertions for the scan sequencer core, with its bind
// depends on ascal_pkg and adc_scan_sequencer_with_calibration_core
`timescale 1ns / 1ps

module ascal_checker
    import ascal_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_beat_t             m_data
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // a beat cannot both wrap the scan and end a calibration
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.scan_wrapped && m_data.calib_done))
        else $error("wrap and calibration end on one beat");

    // the mux returns to channel 0 when a calibration ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.calib_done |-> m_data.mux_channel == 3'd0)
        else $error("mux not at channel 0 after calibration");

endmodule

bind adc_scan_sequencer_with_calibration_core ascal_checker u_ascal_checker (.*);

[bench/testbench.sv]
// testbench: self-checking bench for adc_scan_sequencer_with_calibration_core
// depends on ascal_pkg and the core rtl; directed table first, then random phases
`timescale 1ns / 1ps

module testbench;
    import ascal_pkg::*;

    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 172;
    localparam int HOLDOFF_LEN  = 400;
    localparam int HOLDOFF_AT   = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        in_beat_t  beat;
        logic      has_exp;
        out_beat_t exp;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_beat_t             m_data;

    adc_scan_sequencer_with_calibration_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // mirror of the register file
    logic        ordered_mirror = 1'b0;
    logic [17:0] order_mirror   = SCAN_ORDER_RESET;
    logic [7:0]  rounds_mirror  = CALIB_ROUNDS_RESET;

    // mirror of the sequencer state
    logic [SAMPLE_BITS-1:0] work_slots [SLOT_COUNT]   = '{default: '0};
    logic [SAMPLE_BITS-1:0] snap_slots [SLOT_COUNT]   = '{default: '0};
    logic [SAMPLE_BITS-1:0] offset_tab [CAL_CHANNELS] = '{default: '0};
    logic [SUM_BITS-1:0]    cal_sums   [CAL_CHANNELS] = '{default: '0};
    logic [2:0]             scan_pos   = '0;
    logic [7:0]             round_ctr  = '0;
    logic [2:0]             cal_chan   = '0;
    logic [7:0]             cal_round  = '0;
    logic                   cal_busy   = 1'b0;

    out_beat_t pending_results [$];
    dir_row_t  dir_rows [$];

    int  errors        = 0;
    int  results_seen  = 0;
    int  items_sent    = 0;
    int  quiet_cycles  = 0;
    bit  sender_gaps   = 1'b1;
    bit  holdoff_done  = 1'b0;

    // advance the state mirror by one command beat and return its result beat
    function automatic out_beat_t step_sequencer(input in_beat_t b);
        out_beat_t           r;
        logic                mux_zero;
        logic [7:0]          eff_rounds;
        logic [SUM_BITS-1:0] quot;
        r = '0;
        mux_zero = 1'b0;
        case (b.cmd)
            CMD_SCAN: begin
                if (!cal_busy) begin
                    work_slots[scan_pos] = b.sample;
                    if (scan_pos == SCAN_LENGTH - 1)
                        scan_pos = '0;
                    else
                        scan_pos = scan_pos + 3'd1;
                    if (scan_pos == 3'd0) begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                            snap_slots[i] = work_slots[i];
                        round_ctr = round_ctr + 8'd1;
                        r.scan_wrapped = 1'b1;
                    end
                end
            end
            CMD_CAL_START: begin
                cal_busy = 1'b1;
                cal_chan = '0;
                cal_round = '0;
                for (int i = 0; i < CAL_CHANNELS; i++)
                    cal_sums[i] = '0;
            end
            CMD_CAL_SAMPLE: begin
                if (cal_busy) begin
                    eff_rounds = (rounds_mirror == 8'd0) ? 8'd1 : rounds_mirror;
                    cal_sums[cal_chan] = cal_sums[cal_chan] + b.sample;
                    cal_chan = cal_chan + 3'd1;
                    if (cal_chan == 3'd0) begin
                        cal_round = cal_round + 8'd1;
                        // a lowered round count ends at the first round at or past it
                        if (cal_round >= eff_rounds) begin
                            for (int i = 0; i < CAL_CHANNELS; i++) begin
                                quot = cal_sums[i] / eff_rounds;
                                offset_tab[i] = quot[SAMPLE_BITS-1:0];
                            end
                            cal_busy = 1'b0;
                            cal_round = '0;
                            r.calib_done = 1'b1;
                            mux_zero = 1'b1;
                        end
                    end
                end
            end
            CMD_READ_SNAP:   r.read_data = snap_slots[b.slot_index];
            CMD_READ_OFFSET: r.read_data = offset_tab[b.slot_index];
            CMD_READ_ROUNDS: round_ctr = round_ctr & b.round_mask;
            default: ;
        endcase
        // next mux channel
        if (mux_zero)
            r.mux_channel = '0;
        else if (cal_busy)
            r.mux_channel = cal_chan;
        else if (!ordered_mirror)
            r.mux_channel = scan_pos;
        else if (scan_pos >= ORDER_ENTRIES)
            r.mux_channel = '0;
        else
            r.mux_channel = order_mirror[3 * scan_pos +: 3];
        r.round_count = round_ctr;
        return r;
    endfunction

    // mostly back to back, sometimes a short gap, rarely a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endfunction

    task automatic add_row(input in_beat_t beat, input logic has_exp, input out_beat_t exp);
        dir_rows.push_back({beat, has_exp, exp});
    endtask

    // offer one beat, wait for it to be taken, record what it should produce
    task automatic send_item(input in_beat_t beat, input logic use_row, input out_beat_t row_exp);
        int        gap;
        out_beat_t pred;
        gap = sender_gaps ? random_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        pred = step_sequencer(beat);
        pending_results.push_back(use_row ? row_exp : pred);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        in_beat_t b;
        b.cmd        = cmd;
        b.sample     = pick_sample();
        b.slot_index = 3'($urandom_range(0, 7));
        if (cmd == CMD_READ_ROUNDS && $urandom_range(0, 4) != 0)
            b.round_mask = 8'hff;
        else
            b.round_mask = 8'($urandom_range(0, 255));
        send_item(b, 1'b0, '0);
    endtask

    // write all three registers on consecutive cycles, block idle
    task automatic write_settings(input logic ordered, input logic [17:0] order,
                                  input logic [7:0] rounds);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ORDERED_SCAN;
        cfg_data  <= CFG_DATA_W'(ordered);
        @(negedge aclk);
        cfg_index <= REG_SCAN_ORDER;
        cfg_data  <= order;
        @(negedge aclk);
        cfg_index <= REG_CALIB_ROUNDS;
        cfg_data  <= CFG_DATA_W'(rounds);
        @(negedge aclk);
        cfg_we <= 1'b0;
        ordered_mirror = ordered;
        order_mirror   = order;
        rounds_mirror  = rounds;
    endtask

    // stimulus
    initial begin
        int          phase_start;
        int          pick;
        int          len;
        logic [7:0]  eff;
        logic [7:0]  rounds_sel;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows, reset settings: unordered scan, one calibration round
        add_row({CMD_READ_SNAP,   10'd0,    3'd0, 8'h00}, 1'b1, {3'd0, 10'd0, 8'd0, 1'b0, 1'b0});
        add_row({CMD_READ_OFFSET, 10'd1023, 3'd7, 8'hff}, 1'b1, {3'd0, 10'd0, 8'd0, 1'b0, 1'b0});
        add_row({CMD_SCAN,        10'd1023, 3'd0, 8'h00}, 1'b1, {3'd1, 10'd0, 8'd0, 1'b0, 1'b0});
        add_row({CMD_SCAN,        10'd0,    3'd7, 8'hff}, 1'b0, '0);
        add_row({CMD_SCAN,        10'd512,  3'd2, 8'h55}, 1'b0, '0);
        add_row({CMD_SCAN,        10'd1,    3'd5, 8'haa}, 1'b0, '0);
        add_row({CMD_SCAN,        10'd1022, 3'd3, 8'h0f}, 1'b0, '0);
        add_row({CMD_SCAN,        10'd341,  3'd4, 8'hf0}, 1'b1, {3'd0, 10'd0, 8'd1, 1'b1, 1'b0});
        add_row({CMD_READ_SNAP,   10'd0,    3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_READ_SNAP,   10'd0,    3'd7, 8'h00}, 1'b0, '0);
        // calibration sample while idle is dropped
        add_row({CMD_CAL_SAMPLE,  10'd777,  3'd1, 8'h00}, 1'b0, '0);
        add_row({CMD_CAL_START,   10'd0,    3'd0, 8'h00}, 1'b0, '0);
        // scan sample during calibration is dropped
        add_row({CMD_SCAN,        10'd100,  3'd0, 8'h00}, 1'b0, '0);
        // restart while calibrating
        add_row({CMD_CAL_START,   10'd0,    3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_CAL_SAMPLE,  10'd1023, 3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_CAL_SAMPLE,  10'd0,    3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_CAL_SAMPLE,  10'd1,    3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_CAL_SAMPLE,  10'd2,    3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_CAL_SAMPLE,  10'd512,  3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_CAL_SAMPLE,  10'd1023, 3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_CAL_SAMPLE,  10'd300,  3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_CAL_SAMPLE,  10'd0,    3'd0, 8'h00}, 1'b1, {3'd0, 10'd0, 8'd1, 1'b0, 1'b1});
        add_row({CMD_READ_OFFSET, 10'd0,    3'd0, 8'h00}, 1'b0, '0);
        add_row({CMD_READ_OFFSET, 10'd0,    3'd7, 8'h00}, 1'b0, '0);
        add_row({CMD_READ_ROUNDS, 10'd0,    3'd0, 8'h00}, 1'b1, {3'd0, 10'd0, 8'd0, 1'b0, 1'b0});
        foreach (dir_rows[i])
            send_item(dir_rows[i].beat, dir_rows[i].has_exp, dir_rows[i].exp);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // leave a calibration running past two rounds under the 255-round setting
            if (phase == 1) begin
                send_cmd(CMD_CAL_START);
                repeat (40) send_cmd(CMD_CAL_SAMPLE);
            end
            // drain before touching registers
            s_valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge aclk);
            case (phase)
                0: write_settings(1'b1, 18'h3ffff, 8'd255);
                1: write_settings(1'b1, 18'h00000, 8'd2);
                2: write_settings(1'b0, 18'($urandom_range(0, 262143)), 8'd1);
                default: begin
                    rounds_sel = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                             : 8'($urandom_range(1, 4));
                    write_settings(1'($urandom_range(0, 1)), 18'($urandom_range(0, 262143)),
                                   rounds_sel);
                end
            endcase
            // lowered round count ends the running calibration at the next round
            if (phase == 1)
                repeat (8) send_cmd(CMD_CAL_SAMPLE);
            sender_gaps = !(phase == 2 || phase == 5);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    // run of scan samples
                    repeat ($urandom_range(1, 18)) send_cmd(CMD_SCAN);
                end else if (pick < 65) begin
                    // calibration, sometimes broken off or interleaved
                    eff = (rounds_mirror == 8'd0) ? 8'd1 : rounds_mirror;
                    len = 8 * eff;
                    if (len > 64)
                        len = $urandom_range(20, 64);
                    if ($urandom_range(0, 99) < 15)
                        len = $urandom_range(1, len);
                    send_cmd(CMD_CAL_START);
                    repeat (len) begin
                        if ($urandom_range(0, 19) == 0)
                            send_cmd(3'($urandom_range(CMD_SCAN, CMD_READ_ROUNDS)));
                        send_cmd(CMD_CAL_SAMPLE);
                    end
                end else if (pick < 90) begin
                    // host reads
                    repeat ($urandom_range(1, 4))
                        send_cmd(3'($urandom_range(CMD_READ_SNAP, CMD_READ_ROUNDS)));
                end else begin
                    send_cmd(3'($urandom_range(CMD_SCAN, CMD_READ_ROUNDS)));
                end
            end
        end

        // wait out the last results and any trailing activity
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result side ready, with one long hold-off and one stretch with no stalls
    initial begin
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                gap = HOLDOFF_LEN;
                holdoff_done = 1'b1;
            end else if (results_seen >= 700 && results_seen < 900) begin
                gap = 0;
            end else begin
                gap = random_gap();
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: mux %0d data %0d rounds %0d wrap %0b done %0b",
                             m_data.mux_channel, m_data.read_data, m_data.round_count,
                             m_data.scan_wrapped, m_data.calib_done);
            end else begin
                want = pending_results.pop_front();
                if (m_data.mux_channel  !== want.mux_channel  ||
                    m_data.read_data    !== want.read_data    ||
                    m_data.round_count  !== want.round_count  ||
                    m_data.scan_wrapped !== want.scan_wrapped ||
                    m_data.calib_done   !== want.calib_done) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result %0d mismatch: exp mux %0d data %0d rounds %0d wrap %0b done %0b, got mux %0d data %0d rounds %0d wrap %0b done %0b",
                                 results_seen, want.mux_channel, want.read_data,
                                 want.round_count, want.scan_wrapped, want.calib_done,
                                 m_data.mux_channel, m_data.read_data, m_data.round_count,
                                 m_data.scan_wrapped, m_data.calib_done);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
